[rtl/core/ictf_pkg.sv]
package ictf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_GYRO_SENS  = 2'd0;
  localparam logic [1:0] REG_STEP_MS    = 2'd1;
  localparam logic [1:0] REG_GYRO_WEIGHT = 2'd2;

  // Register reset values.
  localparam logic [15:0] SENS_RESET   = 16'd131;
  localparam logic [15:0] STEP_RESET   = 16'd100;
  localparam logic [16:0] WEIGHT_RESET = 17'd62915;
  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;

  // CORDIC datapath width and iteration count.
  localparam int unsigned CW = 44;
  localparam int unsigned CORDIC_ITERS = 23;
  localparam logic signed [31:0] DEG90 = 32'sd5898240;

  // Angle of atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/imu_complementary_tilt_filter.sv]
// Complementary tilt filter. Each input transfer carries one accelerometer and one gyro
// triple; each produces one output transfer with filtered roll and pitch and integrated
// yaw, all in degrees times 65536. The block handles one sample at a time; the longest
// part of its work is the 48-step restoring divider that scales each of the three gyro
// rates; two 23-step CORDIC passes and a 24-step square root make up most of the rest.
// The input is ready only while the block is idle, and a finished result waits in the
// output register while the next sample is processed.
module imu_complementary_tilt_filter
  import ictf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // roll_out, pitch_out, yaw_out
  output logic [95:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_ROLL_INIT, S_CORDIC, S_SQ1, S_SQ2, S_SQRT, S_PITCH_INIT,
    S_GMUL, S_DIV, S_GSUM, S_BL1, S_BL2, S_DONE
  } state_e;

  state_e state_q;
  logic [5:0] cnt_q;
  logic pass_q;
  logic [1:0] axis_q;

  logic [15:0] sens_q, step_q;
  logic [16:0] weight_q;

  logic signed [15:0] smp_q [6];
  logic signed [31:0] angle_q [3];
  logic signed [31:0] acc_roll_q, acc_pitch_q, g_q;

  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [31:0] ang_q;
  logic zero_q;

  logic [47:0] s_q, r_q;
  logic signed [51:0] acc_q;

  logic [25:0] den_q;
  logic [26:0] rem_q;
  logic [47:0] dq_q;
  logic neg_q;

  logic [95:0] out_q;
  logic out_vld_q;

  // Effective register values after the special-case rules.
  logic [15:0] sens_eff;
  logic [16:0] w_eff, w_cmp;
  assign sens_eff = (sens_q == 16'd0) ? 16'd1 : sens_q;
  assign w_eff = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign w_cmp = WEIGHT_ONE - w_eff;

  // Shared multiplier.
  logic signed [17:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [50:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ1: begin
        mul_a = 18'(smp_q[1]);
        mul_b = 33'(smp_q[1]);
      end
      S_SQ2: begin
        mul_a = 18'(smp_q[2]);
        mul_b = 33'(smp_q[2]);
      end
      S_GMUL: begin
        mul_a = $signed({2'b00, step_q});
        mul_b = 33'(smp_q[3'd3 + 3'(axis_q)]);
      end
      S_BL1: begin
        mul_a = $signed({1'b0, w_eff});
        mul_b = 33'(g_q);
      end
      S_BL2: begin
        mul_a = $signed({1'b0, w_cmp});
        mul_b = 33'((axis_q == 2'd0) ? acc_roll_q : acc_pitch_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 51'(mul_a) * 51'(mul_b);
  end

  // CORDIC operands for the roll and pitch passes.
  logic signed [CW-1:0] cin_y, cin_x;
  always_comb begin
    if (state_q == S_ROLL_INIT) begin
      cin_y = {{4{smp_q[1][15]}}, smp_q[1], 24'd0};
      cin_x = {{4{smp_q[2][15]}}, smp_q[2], 24'd0};
    end else begin
      cin_y = -{{4{smp_q[0][15]}}, smp_q[0], 24'd0};
      cin_x = {4'd0, r_q[23:0], 16'd0};
    end
  end

  // CORDIC micro-rotation terms.
  logic signed [CW-1:0] dx, dy;
  logic signed [31:0] tab;
  assign dx = cy_q >>> cnt_q[4:0];
  assign dy = cx_q >>> cnt_q[4:0];
  assign tab = 32'($signed({1'b0, atan_lut(cnt_q[4:0])}));

  // Square root step terms.
  logic [47:0] sq_bit, sq_trial;
  assign sq_bit = 48'd1 << {cnt_q[4:0], 1'b0};
  assign sq_trial = r_q + sq_bit;

  // Divider step.
  logic [26:0] div_trial;
  assign div_trial = {rem_q[25:0], dq_q[47]};

  // Gyro increment added to the kept angle.
  logic signed [51:0] gyro_sum;
  assign gyro_sum = 52'(angle_q[axis_q]) +
                    (neg_q ? -$signed({4'd0, dq_q}) : $signed({4'd0, dq_q}));

  logic signed [51:0] blend_sum;
  assign blend_sum = acc_q + 52'(mul_p) + 52'sd32768;

  logic [31:0] prod_mag;
  assign prod_mag = mul_p[50] ? 32'(-mul_p) : mul_p[31:0];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= SENS_RESET;
      step_q <= STEP_RESET;
      weight_q <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GYRO_SENS:   sens_q <= cfg_data_i[15:0];
        REG_STEP_MS:     step_q <= cfg_data_i[15:0];
        REG_GYRO_WEIGHT: weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pass_q <= 1'b0;
      axis_q <= '0;
      out_vld_q <= 1'b0;
      angle_q[0] <= '0;
      angle_q[1] <= '0;
      angle_q[2] <= '0;
    end else begin
      // The output register empties unless a new result is loaded in the same cycle.
      if (out_vld_q && m_axis_tready_i && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            for (int k = 0; k < 6; k++) begin
              smp_q[k] <= s_axis_tdata_i[16*k +: 16];
            end
            state_q <= S_ROLL_INIT;
          end
        end
        S_ROLL_INIT, S_PITCH_INIT: begin
          pass_q <= (state_q == S_PITCH_INIT);
          zero_q <= (cin_x == '0) && (cin_y == '0);
          cnt_q <= '0;
          if (cin_x[CW-1] && !cin_y[CW-1]) begin
            cx_q <= cin_y;
            cy_q <= -cin_x;
            ang_q <= DEG90;
          end else if (cin_x[CW-1]) begin
            cx_q <= -cin_y;
            cy_q <= cin_x;
            ang_q <= -DEG90;
          end else begin
            cx_q <= cin_x;
            cy_q <= cin_y;
            ang_q <= '0;
          end
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + dx;
            cy_q <= cy_q - dy;
            ang_q <= ang_q + tab;
          end else begin
            cx_q <= cx_q - dx;
            cy_q <= cy_q + dy;
            ang_q <= ang_q - tab;
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(CORDIC_ITERS - 1)) begin
            if (!pass_q) begin
              acc_roll_q <= zero_q ? '0 : ((cy_q > 0) ? ang_q + tab : ang_q - tab);
              state_q <= S_SQ1;
            end else begin
              acc_pitch_q <= zero_q ? '0 : ((cy_q > 0) ? ang_q + tab : ang_q - tab);
              axis_q <= '0;
              state_q <= S_GMUL;
            end
          end
        end
        S_SQ1: begin
          acc_q <= 52'(mul_p);
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          s_q <= {acc_q[31:0] + mul_p[31:0], 16'd0};
          r_q <= '0;
          cnt_q <= 6'd23;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (s_q >= sq_trial) begin
            s_q <= s_q - sq_trial;
            r_q <= (r_q >> 1) + sq_bit;
          end else begin
            r_q <= r_q >> 1;
          end
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= S_PITCH_INIT;
          end
        end
        S_GMUL: begin
          den_q <= 26'(sens_eff * 26'd1000);
          neg_q <= mul_p[50];
          dq_q <= {prod_mag, 16'd0} + 48'(26'(sens_eff * 26'd1000) >> 1);
          rem_q <= '0;
          cnt_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_trial >= {1'b0, den_q}) begin
            rem_q <= div_trial - {1'b0, den_q};
            dq_q <= {dq_q[46:0], 1'b1};
          end else begin
            rem_q <= div_trial;
            dq_q <= {dq_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd47) begin
            state_q <= S_GSUM;
          end
        end
        S_GSUM: begin
          if (axis_q == 2'd2) begin
            angle_q[2] <= sat32(gyro_sum);
            state_q <= S_DONE;
          end else begin
            g_q <= sat32(gyro_sum);
            state_q <= S_BL1;
          end
        end
        S_BL1: begin
          acc_q <= 52'(mul_p);
          state_q <= S_BL2;
        end
        S_BL2: begin
          angle_q[axis_q] <= sat32(blend_sum >>> 16);
          axis_q <= axis_q + 2'd1;
          state_q <= S_GMUL;
        end
        S_DONE: begin
          if (!out_vld_q || m_axis_tready_i) begin
            out_q <= {angle_q[2], angle_q[1], angle_q[0]};
            out_vld_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == S_ROLL_INIT)
    else $error("accepted sample did not start processing");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == S_DONE)
    else $error("result appeared outside the final step");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> den_q != '0)
    else $error("divider running with a zero divisor");
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BL1 || state_q == S_BL2 |-> axis_q != 2'd2)
    else $error("blend started for the yaw axis");
`endif

endmodule

[tb/tb.sv]
module tb;
  import ictf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
  logic [95:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // roll_out, pitch_out, yaw_out
  logic [95:0] m_axis_tdata_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [16:0] cfg_data_i;

  imu_complementary_tilt_filter dut (.*);

  typedef struct packed {
    logic signed [31:0] yaw;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
  } attitude_t;

  typedef struct packed {
    logic signed [15:0] rz;
    logic signed [15:0] ry;
    logic signed [15:0] rx;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } imu_sample_t;

  // Predictor state and registers.
  logic [15:0]        sens_q;
  logic [15:0]        step_q;
  logic [16:0]        weight_q;
  logic signed [31:0] roll_q;
  logic signed [31:0] pitch_q;
  logic signed [31:0] yaw_q;

  attitude_t attitude_fifo[$];
  int        mismatch_cnt;
  longint    cycle_cnt;
  bit        stall_hold;
  int        burst_mode;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     DRAIN_CYCLES = 600;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_deg(int idx);
    longint angle_lut[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                              14, 7, 4, 2, 1};
    return angle_lut[idx];
  endfunction

  // Vectoring CORDIC angle of (x, y) in degrees times 65536.
  function automatic longint vector_angle(longint y, longint x);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < 23; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_deg(i);
      end else begin
        x -= dx; y += dy; ang -= atan_deg(i);
      end
    end
    return ang;
  endfunction

  function automatic longint int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Angle step from one gyro rate, rounded half away from zero.
  function automatic longint rate_step(longint rate);
    longint den, num;
    den = (sens_q == 0 ? 64'sd1 : longint'(sens_q)) * 1000;
    num = rate * longint'(step_q) * 65536;
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic signed [31:0] mix_angle(longint g, longint a);
    longint w;
    w = (weight_q > 17'd65536) ? 64'sd65536 : longint'(weight_q);
    return 32'(clamp32(shr_floor(w * g + (65536 - w) * a + 32768, 16)));
  endfunction

  function automatic attitude_t predict_attitude(imu_sample_t s);
    longint ax, ay, az, acc_roll, acc_pitch, mag;
    attitude_t r;
    ax = s.ax; ay = s.ay; az = s.az;
    acc_roll = vector_angle(ay * 16777216, az * 16777216);
    mag = int_sqrt(longint'(ay * ay + az * az) << 16);
    acc_pitch = vector_angle(-ax * 256 * 65536, mag * 65536);
    roll_q = mix_angle(clamp32(longint'(roll_q) + rate_step(s.rx)), acc_roll);
    pitch_q = mix_angle(clamp32(longint'(pitch_q) + rate_step(s.ry)), acc_pitch);
    yaw_q = 32'(clamp32(longint'(yaw_q) + rate_step(s.rz)));
    r.roll = roll_q; r.pitch = pitch_q; r.yaw = yaw_q;
    return r;
  endfunction

  // Register write while the block is idle; the predictor follows.
  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_GYRO_SENS:   sens_q = val[15:0];
      REG_STEP_MS:     step_q = val[15:0];
      REG_GYRO_WEIGHT: weight_q = val;
      default: ;
    endcase
  endtask

  // Offer one sample and hold it until the transfer happens. Valid stays high on
  // return so that back-to-back samples follow without a gap; a gap or wait_idle
  // drops it.
  task automatic send_sample(imu_sample_t s);
    int gap;
    if (burst_mode != 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    do @(posedge clk_i); while (!s_axis_tready_o);
    attitude_fifo.push_back(predict_attitude(s));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (attitude_fifo.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    s.ax = rand16(); s.ay = rand16(); s.az = rand16();
    if ($urandom_range(0, 2) != 0) begin
      // Modest gyro rates between -2000 and 2000; the accelerometer values stay random.
      s.rx = 16'($urandom_range(0, 4000)) - 16'sd2000;
      s.ry = 16'($urandom_range(0, 4000)) - 16'sd2000;
      s.rz = 16'($urandom_range(0, 4000)) - 16'sd2000;
    end else begin
      s.rx = rand16(); s.ry = rand16(); s.rz = rand16();
    end
    return s;
  endfunction

  function automatic imu_sample_t make_sample(int ax, int ay, int az, int rx, int ry, int rz);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.rx = 16'(rx); s.ry = 16'(ry); s.rz = 16'(rz);
    return s;
  endfunction

  // Extremes, zero vectors, samples in several quadrants and yaw saturation.
  task automatic test_directed();
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 16384, 131, -131, 0));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(100, 500, -16384, 0, 0, 0));
    send_sample(make_sample(-100, -500, -16384, 0, 0, 0));
    send_sample(make_sample(0, 16384, 0, 0, 0, 0));
    send_sample(make_sample(0, -16384, 0, 0, 0, 0));
    send_sample(make_sample(16384, 0, 0, -1, 1, -1));
    send_sample(make_sample(-16384, 0, 0, 1, -1, 1));
    wait_idle();
    // Large gain pushes yaw into both saturation limits.
    write_reg(REG_GYRO_SENS, 17'd1);
    write_reg(REG_STEP_MS, 17'd65535);
    write_reg(REG_GYRO_WEIGHT, 17'd65536);
    for (int i = 0; i < 4; i++) send_sample(make_sample(0, 0, 1, 32767, 32767, 32767));
    for (int i = 0; i < 4; i++)
      send_sample(make_sample(0, 0, 1, -32768, -32768, -32768));
    wait_idle();
  endtask

  // Special register values: zero sensitivity, zero step, weight above one.
  task automatic test_register_edges();
    write_reg(REG_GYRO_SENS, 17'd0);
    write_reg(REG_STEP_MS, 17'd0);
    write_reg(REG_GYRO_WEIGHT, 17'h1ffff);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    wait_idle();
    write_reg(REG_STEP_MS, 17'd1);
    write_reg(REG_GYRO_WEIGHT, 17'd0);
    for (int i = 0; i < 4; i++) send_sample(random_sample());
    wait_idle();
  endtask

  // Random phases across several register settings.
  task automatic test_random();
    logic [16:0] sens_set[5] = '{17'd131, 17'd1, 17'd65535, 17'd16, 17'd0};
    logic [16:0] step_set[5] = '{17'd100, 17'd65535, 17'd1, 17'd10, 17'd0};
    logic [16:0] wgt_set[5] = '{17'd62915, 17'd65536, 17'd0, 17'd32768, 17'd131071};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_GYRO_SENS, sens_set[p]);
      write_reg(REG_STEP_MS, step_set[p]);
      write_reg(REG_GYRO_WEIGHT, wgt_set[p]);
      if (p == 4) write_reg(REG_GYRO_SENS, 17'($urandom));
      burst_mode = p % 2;
      for (int i = 0; i < 160; i++) send_sample(random_sample());
      wait_idle();
    end
  endtask

  // Long receiver hold-off while samples keep coming.
  task automatic test_backpressure();
    stall_hold = 1'b1;
    burst_mode = 0;
    fork
      begin
        repeat (3000) @(negedge clk_i);
        stall_hold = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_sample(random_sample());
    join
    wait_idle();
  endtask

  // Receiver stalls on its own pattern, with stall-free stretches.
  always @(negedge clk_i) begin
    if (stall_hold) begin
      m_axis_tready_i <= 1'b0;
    end else if ((cycle_cnt / 2000) % 3 == 0) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    attitude_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (attitude_fifo.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = attitude_fifo.pop_front();
        if (got.roll !== want.roll || got.pitch !== want.pitch || got.yaw !== want.yaw) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/act)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    mismatch_cnt = 0;
    stall_hold = 1'b0;
    burst_mode = 1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_GYRO_SENS;
    cfg_data_i = '0;
    sens_q = SENS_RESET;
    step_q = STEP_RESET;
    weight_q = WEIGHT_RESET;
    roll_q = 0;
    pitch_q = 0;
    yaw_q = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_register_edges();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatch_cnt == 0 && attitude_fifo.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[imu_complementary_tilt_filter.f]
rtl/core/ictf_pkg.sv
rtl/core/imu_complementary_tilt_filter.sv
tb/tb.sv
